>>> hdl/feps_pkg.sv
package feps_pkg;

  localparam int unsigned FLASH_BYTES_DEF = 1048576;

  localparam int ADDR_W = 24;
  localparam int CUR_W  = 25;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 9;

  localparam logic [CUR_W-1:0] STEP_64K = 25'h001_0000;
  localparam logic [CUR_W-1:0] STEP_32K = 25'h000_8000;
  localparam logic [CUR_W-1:0] STEP_4K  = 25'h000_1000;
  localparam logic [CNT_W-1:0] PAGE_BYTES = 9'd256;

  typedef enum logic [1:0] {
    OP_ERASE    = 2'd0,
    OP_WRITE    = 2'd1,
    OP_CONTINUE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ISSUED = 2'd0,
    ST_DONE   = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_CHIP = 3'd1,
    CMD_B64  = 3'd2,
    CMD_B32  = 3'd3,
    CMD_S4   = 3'd4,
    CMD_PAGE = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t              pending_kind;
    logic [CUR_W-1:0]  cursor;
    logic [CUR_W-1:0]  range_end;
    logic [LEN_W-1:0]  bytes_left;
  } state_t;

  typedef struct packed {
    status_t           status;
    cmd_t              command;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

>>> hdl/feps_plan.sv
module feps_plan import feps_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  opcode_t           op,
  input  logic [ADDR_W-1:0] from_addr,
  input  logic [ADDR_W-1:0] upto_addr,
  input  logic [LEN_W-1:0]  len,
  input  state_t            cur,
  output state_t            nxt,
  output result_t           res
);

  localparam logic [CUR_W-1:0]  SIZE = CUR_W'(FLASH_BYTES);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(FLASH_BYTES - 1);

  logic              idle;
  logic [ADDR_W-1:0] upto_c;
  logic              from_bad;
  logic              erase_bad;
  logic              is_chip;
  logic              write_bad;
  logic [CUR_W-1:0]  step;
  logic [CUR_W-1:0]  ecur;
  logic [CUR_W-1:0]  eend;
  logic [CUR_W-1:0]  span;
  logic              e_done;
  cmd_t              e_kind;
  logic [CUR_W-1:0]  wcur;
  logic [LEN_W-1:0]  wleft;
  logic [CNT_W-1:0]  chunk_raw;
  logic [CNT_W-1:0]  chunk;
  logic [CUR_W-1:0]  w_cur_nxt;
  logic [LEN_W-1:0]  w_left_nxt;
  logic              w_done;
  result_t           r_err;
  result_t           r_done;
  result_t           r_erase;
  result_t           r_page;

  assign idle      = (cur.pending_kind == CMD_NONE);
  assign upto_c    = (({1'b0, upto_addr} >= SIZE) || (upto_addr == '0)) ? LAST : upto_addr;
  assign from_bad  = ({1'b0, from_addr} >= SIZE);
  assign erase_bad = from_bad || (upto_c < from_addr);
  assign is_chip   = (from_addr == '0) && (upto_c == LAST);
  assign write_bad = from_bad || (({1'b0, from_addr} + {{(CUR_W-LEN_W){1'b0}}, len}) > SIZE);

  always_comb begin
    case (cur.pending_kind)
      CMD_B64: step = STEP_64K;
      CMD_B32: step = STEP_32K;
      default: step = STEP_4K;
    endcase
  end

  // erase planning
  assign ecur   = (op == OP_ERASE) ? {1'b0, from_addr[ADDR_W-1:12], 12'h000}
                                   : cur.cursor + step;
  assign eend   = (op == OP_ERASE) ? ({1'b0, upto_c[ADDR_W-1:12], 12'h000} + STEP_4K)
                                   : cur.range_end;
  assign e_done = (ecur >= eend);
  assign span   = eend - ecur;

  always_comb begin
    if ((ecur[15:0] == '0) && (span >= STEP_64K)) begin
      e_kind = CMD_B64;
    end else if ((ecur[14:0] == '0) && (span >= STEP_32K)) begin
      e_kind = CMD_B32;
    end else begin
      e_kind = CMD_S4;
    end
  end

  // page program planning
  assign wcur       = (op == OP_WRITE) ? {1'b0, from_addr} : cur.cursor;
  assign wleft      = (op == OP_WRITE) ? len : cur.bytes_left;
  assign w_done     = (wleft == '0);
  assign chunk_raw  = PAGE_BYTES - {1'b0, wcur[7:0]};
  assign chunk      = ({{(LEN_W-CNT_W){1'b0}}, chunk_raw} > wleft) ? wleft[CNT_W-1:0]
                                                                  : chunk_raw;
  assign w_cur_nxt  = wcur + {{(CUR_W-CNT_W){1'b0}}, chunk};
  assign w_left_nxt = wleft - {{(LEN_W-CNT_W){1'b0}}, chunk};

  always_comb begin
    r_err.status    = ST_ERROR;
    r_err.command   = CMD_NONE;
    r_err.address   = '0;
    r_err.count     = '0;
    r_done          = r_err;
    r_done.status   = ST_DONE;
    r_erase.status  = ST_ISSUED;
    r_erase.command = e_kind;
    r_erase.address = ecur[ADDR_W-1:0];
    r_erase.count   = '0;
    r_page.status   = ST_ISSUED;
    r_page.command  = CMD_PAGE;
    r_page.address  = wcur[ADDR_W-1:0];
    r_page.count    = chunk;
  end

  always_comb begin
    nxt = cur;
    res = r_err;
    case (op)
      OP_ERASE: begin
        if (idle && !erase_bad) begin
          if (is_chip) begin
            nxt.pending_kind = CMD_CHIP;
            res              = r_err;
            res.status       = ST_ISSUED;
            res.command      = CMD_CHIP;
          end else begin
            nxt.cursor    = ecur;
            nxt.range_end = eend;
            if (e_done) begin
              nxt.pending_kind = CMD_NONE;
              res              = r_done;
            end else begin
              nxt.pending_kind = e_kind;
              res              = r_erase;
            end
          end
        end
      end
      OP_WRITE, OP_CONTINUE: begin
        if ((op == OP_WRITE) ? (idle && !write_bad) : (cur.pending_kind == CMD_PAGE)) begin
          nxt.cursor     = wcur;
          nxt.bytes_left = wleft;
          if (w_done) begin
            nxt.pending_kind = CMD_NONE;
            res              = r_done;
          end else begin
            nxt.cursor       = w_cur_nxt;
            nxt.bytes_left   = w_left_nxt;
            nxt.pending_kind = CMD_PAGE;
            res              = r_page;
          end
        end else if (op == OP_CONTINUE) begin
          case (cur.pending_kind)
            CMD_CHIP: begin
              nxt.pending_kind = CMD_NONE;
              res              = r_done;
            end
            CMD_B64, CMD_B32, CMD_S4: begin
              nxt.cursor = ecur;
              if (e_done) begin
                nxt.pending_kind = CMD_NONE;
                res              = r_done;
              end else begin
                nxt.pending_kind = e_kind;
                res              = r_erase;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/flash_erase_program_sequencer.sv
// Plans the command stream for erasing or programming a NOR flash of FLASH_BYTES bytes.
// Each input word (start erase, start write, or continue after the last command finished)
// yields exactly one result word: a command to issue, done, or a rejection. An item may be
// accepted every cycle while the output is not stalled; it passes through the input
// register, then through the planning logic and the sequencer state update into the result
// register. The result register is separated from the input register so a new word is taken
// while a finished result still waits; a stall on the result side holds both stages once
// they are full.
module flash_erase_program_sequencer import feps_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_start_address,
  input  logic [ADDR_W-1:0] in_end_address,
  input  logic [LEN_W-1:0]  in_write_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [2:0]        out_command,
  output logic [ADDR_W-1:0] out_command_address,
  output logic [CNT_W-1:0]  out_byte_count
);

  logic              s1_vld_r;
  logic [1:0]        op_r;
  logic [ADDR_W-1:0] from_r;
  logic [ADDR_W-1:0] upto_r;
  logic [LEN_W-1:0]  len_r;
  state_t            st_r;
  state_t            st_nxt;
  result_t           res_nxt;
  result_t           res_r;
  logic              out_vld_r;
  logic              adv;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r   <= in_opcode;
      from_r <= in_start_address;
      upto_r <= in_end_address;
      len_r  <= in_write_length;
    end
  end

  feps_plan #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_plan (
    .op        (opcode_t'(op_r)),
    .from_addr (from_r),
    .upto_addr (upto_r),
    .len       (len_r),
    .cur       (st_r),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_status          = res_r.status;
  assign out_command         = res_r.command;
  assign out_command_address = res_r.address;
  assign out_byte_count      = res_r.count;

endmodule

>>> hdl/feps_checker.sv
module feps_checker import feps_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [2:0]        out_command,
  input logic [ADDR_W-1:0] out_command_address,
  input logic [CNT_W-1:0]  out_byte_count
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_command)
      && $stable(out_command_address) && $stable(out_byte_count))
    else $error("result word changed under stall");

  // done and error carry no command
  a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ISSUED |->
      out_command == CMD_NONE && out_command_address == '0 && out_byte_count == '0)
    else $error("done or error word carries a command");

  // page program stays inside one page
  a_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_PAGE |->
      out_byte_count != '0
      && ({1'b0, out_command_address[7:0]} + out_byte_count) <= PAGE_BYTES)
    else $error("page program chunk crosses a page");

  // erase commands are aligned and carry no byte count
  a_erase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == CMD_B64 || out_command == CMD_B32
      || out_command == CMD_S4 || out_command == CMD_CHIP) |->
      out_byte_count == '0 && out_command_address[11:0] == '0
      && (out_command != CMD_B64 || out_command_address[15:0] == '0)
      && (out_command != CMD_B32 || out_command_address[14:0] == '0)
      && (out_command != CMD_CHIP || out_command_address == '0))
    else $error("misaligned erase command");

endmodule

bind flash_erase_program_sequencer feps_checker u_feps_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_command         (out_command),
  .out_command_address (out_command_address),
  .out_byte_count      (out_byte_count)
);

>>> bench/flash_sequencer_checker.sv
`timescale 1ns / 100ps
module flash_sequencer_checker import feps_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [ADDR_W-1:0] in_start_address,
  input  logic [ADDR_W-1:0] in_end_address,
  input  logic [LEN_W-1:0]  in_write_length,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic [2:0]        out_command,
  input  logic [ADDR_W-1:0] out_command_address,
  input  logic [CNT_W-1:0]  out_byte_count,
  output logic              plan_busy,
  output int                words_owed,
  output int                fail_count
);

  cmd_t             pend_cmd;
  logic [CUR_W-1:0] cur_addr;
  logic [CUR_W-1:0] erase_end;
  logic [LEN_W-1:0] prog_left;
  result_t          planned_words[$];

  function automatic result_t make_word(status_t st, cmd_t cmd, logic [31:0] addr,
                                        logic [31:0] cnt);
    result_t r;
    r.status  = st;
    r.command = cmd;
    r.address = addr[ADDR_W-1:0];
    r.count   = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic result_t next_erase();
    logic [31:0] span;
    if (cur_addr >= erase_end) begin
      pend_cmd = CMD_NONE;
      return make_word(ST_DONE, CMD_NONE, 32'd0, 32'd0);
    end
    span = {7'd0, erase_end} - {7'd0, cur_addr};
    if (cur_addr[15:0] == 16'h0 && span >= 32'h1_0000) begin
      pend_cmd = CMD_B64;
    end else if (cur_addr[14:0] == 15'h0 && span >= 32'h8000) begin
      pend_cmd = CMD_B32;
    end else begin
      pend_cmd = CMD_S4;
    end
    return make_word(ST_ISSUED, pend_cmd, {7'd0, cur_addr}, 32'd0);
  endfunction

  function automatic result_t next_page();
    logic [31:0] chunk;
    logic [31:0] addr;
    if (prog_left == '0) begin
      pend_cmd = CMD_NONE;
      return make_word(ST_DONE, CMD_NONE, 32'd0, 32'd0);
    end
    addr  = {7'd0, cur_addr};
    chunk = 32'd256 - {24'd0, cur_addr[7:0]};
    if (chunk > {16'd0, prog_left}) begin
      chunk = {16'd0, prog_left};
    end
    cur_addr  = cur_addr + chunk[CUR_W-1:0];
    prog_left = prog_left - chunk[LEN_W-1:0];
    pend_cmd  = CMD_PAGE;
    return make_word(ST_ISSUED, CMD_PAGE, addr, chunk);
  endfunction

  function automatic result_t plan_word(logic [1:0] op, logic [ADDR_W-1:0] from,
                                        logic [ADDR_W-1:0] upto, logic [LEN_W-1:0] len);
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] flash_sz;
    logic [31:0] tmp;
    result_t     reject;
    first    = {8'd0, from};
    last     = {8'd0, upto};
    flash_sz = FLASH_BYTES;
    reject   = make_word(ST_ERROR, CMD_NONE, 32'd0, 32'd0);
    case (op)
      OP_ERASE: begin
        if (pend_cmd != CMD_NONE) return reject;
        if (last >= flash_sz || last == 32'd0) last = flash_sz - 32'd1;
        if (first >= flash_sz || last < first) return reject;
        if (first == 32'd0 && last == flash_sz - 32'd1) begin
          pend_cmd = CMD_CHIP;
          return make_word(ST_ISSUED, CMD_CHIP, 32'd0, 32'd0);
        end
        tmp       = first & 32'hFFFF_F000;
        cur_addr  = tmp[CUR_W-1:0];
        tmp       = (last & 32'hFFFF_F000) + 32'h1000;
        erase_end = tmp[CUR_W-1:0];
        return next_erase();
      end
      OP_WRITE: begin
        if (pend_cmd != CMD_NONE || first >= flash_sz ||
            first + {16'd0, len} > flash_sz) return reject;
        cur_addr  = first[CUR_W-1:0];
        prog_left = len;
        return next_page();
      end
      OP_CONTINUE: begin
        case (pend_cmd)
          CMD_CHIP: begin
            pend_cmd = CMD_NONE;
            return make_word(ST_DONE, CMD_NONE, 32'd0, 32'd0);
          end
          CMD_B64: begin
            cur_addr = cur_addr + STEP_64K;
            return next_erase();
          end
          CMD_B32: begin
            cur_addr = cur_addr + STEP_32K;
            return next_erase();
          end
          CMD_S4: begin
            cur_addr = cur_addr + STEP_4K;
            return next_erase();
          end
          CMD_PAGE: return next_page();
          default: return reject;
        endcase
      end
      default: return reject;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      pend_cmd   = CMD_NONE;
      cur_addr   = '0;
      erase_end  = '0;
      prog_left  = '0;
      fail_count = 0;
      planned_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (planned_words.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          want = planned_words.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_command !== want.command) begin
            $error("command: expected %0d, got %0d", want.command, out_command);
            fail_count++;
          end
          if (out_command_address !== want.address) begin
            $error("command_address: expected %h, got %h", want.address,
                   out_command_address);
            fail_count++;
          end
          if (out_byte_count !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, out_byte_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        planned_words.push_back(plan_word(in_opcode, in_start_address, in_end_address,
                                          in_write_length));
      end
    end
    plan_busy  <= (pend_cmd != CMD_NONE);
    words_owed <= planned_words.size();
  end

endmodule

>>> bench/tb_flash_erase_program_sequencer.sv
`timescale 1ns / 100ps
module tb_flash_erase_program_sequencer;
  import feps_pkg::*;

  localparam int unsigned SIZE = FLASH_BYTES_DEF;
  localparam logic [1:0]  OP_UNKNOWN = 2'd3;
  localparam int RAND_WORDS     = 750;
  localparam int HOLD_CYCLES    = 90;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = '0;
  logic [ADDR_W-1:0] in_start_address = '0;
  logic [ADDR_W-1:0] in_end_address = '0;
  logic [LEN_W-1:0]  in_write_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [1:0]        out_status;
  logic [2:0]        out_command;
  logic [ADDR_W-1:0] out_command_address;
  logic [CNT_W-1:0]  out_byte_count;

  logic plan_busy;
  int   words_owed;
  int   fail_count;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_asks = 0;
  int hold_seen = 0;
  int words_sent = 0;
  int quiet = 0;

  always #6 clk = ~clk;

  flash_erase_program_sequencer #(.FLASH_BYTES(SIZE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_start_address(in_start_address), .in_end_address(in_end_address),
    .in_write_length(in_write_length),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_command(out_command), .out_command_address(out_command_address),
    .out_byte_count(out_byte_count)
  );

  flash_sequencer_checker #(.FLASH_BYTES(SIZE)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_start_address(in_start_address), .in_end_address(in_end_address),
    .in_write_length(in_write_length),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_command(out_command), .out_command_address(out_command_address),
    .out_byte_count(out_byte_count),
    .plan_busy(plan_busy), .words_owed(words_owed), .fail_count(fail_count)
  );

  task automatic send_word(input logic [1:0] op, input logic [ADDR_W-1:0] sa,
                           input logic [ADDR_W-1:0] ea, input logic [LEN_W-1:0] len);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_start_address <= sa;
    in_end_address   <= ea;
    in_write_length  <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_noise();
    send_word(2'($urandom_range(0, 3)), ADDR_W'($urandom), ADDR_W'($urandom),
              LEN_W'($urandom));
  endtask

  // continue words until the planned operation is over; the busy flag lags one word
  task automatic finish_op(input bit noisy);
    do begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_noise();
      end else begin
        send_word(OP_CONTINUE, ADDR_W'($urandom), ADDR_W'($urandom), LEN_W'($urandom));
      end
    end while (plan_busy);
  endtask

  task automatic random_erase();
    int from;
    int upto;
    case ($urandom_range(0, 3))
      0: from = $urandom_range(0, SIZE - 1);
      1: from = $urandom_range(0, SIZE - 1) & 32'hFFF000;
      2: from = $urandom_range(0, SIZE - 1) & 32'hFF8000;
      default: from = $urandom_range(0, SIZE - 1) & 32'hFF0000;
    endcase
    case ($urandom_range(0, 19))
      0, 1: upto = 0;
      2, 3: upto = $urandom_range(SIZE, 24'hFFFFFF);
      4: upto = (from > 0) ? $urandom_range(0, from - 1) : 0;
      5: begin
        from = 0;
        upto = SIZE - 1;
      end
      6: from = $urandom_range(SIZE, 24'hFFFFFF);
      default: upto = from + $urandom_range(0, 32'h30000);
    endcase
    send_word(OP_ERASE, ADDR_W'(from), ADDR_W'(upto), LEN_W'($urandom));
    finish_op(1'b1);
  endtask

  task automatic random_write();
    int len;
    int from;
    case ($urandom_range(0, 19))
      0: len = 0;
      1: len = $urandom_range(0, 3000);
      2, 3, 4, 5, 6: len = $urandom_range(1, 600);
      default: len = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0: from = $urandom_range(SIZE, 24'hFFFFFF);
      1: from = $urandom_range(SIZE - len + 1, SIZE);
      2, 3: from = ($urandom_range(0, SIZE - len) & 32'hFFFF00) | $urandom_range(8'hF0, 8'hFF);
      default: from = $urandom_range(0, SIZE - len);
    endcase
    if (from + len > SIZE && from < SIZE && $urandom_range(0, 1)) from = SIZE - len;
    send_word(OP_WRITE, ADDR_W'(from), ADDR_W'($urandom), LEN_W'(len));
    finish_op(1'b1);
  endtask

  initial begin : receiver
    int gap;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        gap += HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_flash_erase_program_sequencer: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_start;
    int next_hold;
    int pick;
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_CONTINUE, '0, '0, '0);
    send_word(OP_UNKNOWN, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    // whole chip, then starts while busy
    send_word(OP_ERASE, '0, '0, '0);
    send_word(OP_ERASE, 24'h1000, 24'h2000, '0);
    send_word(OP_WRITE, '0, '0, 16'h10);
    finish_op(1'b0);
    send_word(OP_ERASE, ADDR_W'(SIZE), '0, '0);
    send_word(OP_ERASE, 24'h5000, 24'h4FFF, '0);
    send_word(OP_ERASE, 24'h1234, 24'h1234, '0);
    finish_op(1'b0);
    send_word(OP_ERASE, 24'h7000, 24'h2FFFF, '0);
    finish_op(1'b0);
    send_word(OP_ERASE, ADDR_W'(SIZE - 1), 24'hFFFFFF, '0);
    finish_op(1'b0);
    send_word(OP_WRITE, ADDR_W'(SIZE - 1), '0, 16'd1);
    finish_op(1'b0);
    send_word(OP_WRITE, ADDR_W'(SIZE), '0, 16'd1);
    send_word(OP_WRITE, 24'hFFF00, '0, 16'h101);
    send_word(OP_WRITE, 24'h10, '0, '0);
    send_word(OP_WRITE, 24'h80, '0, 16'd300);
    finish_op(1'b0);

    rand_start = words_sent;
    next_hold = 0;
    while (words_sent - rand_start < RAND_WORDS) begin
      phase = ((words_sent - rand_start) / 150) % 4;
      tx_idle = (phase == 0 || phase == 1);
      rx_idle = (phase == 0 || phase == 2);
      if (words_sent - rand_start >= next_hold) begin
        hold_asks++;
        next_hold += 300;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        random_erase();
      end else if (pick < 85) begin
        random_write();
      end else begin
        send_noise();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_owed == 0) begin
      $display("tb_flash_erase_program_sequencer: done, clean");
    end else begin
      $display("tb_flash_erase_program_sequencer: done, errors");
    end
    $finish;
  end

endmodule
